/* rtl/lse_pkg.sv */
// Package for the LSB stego embedder: section codes, register indexes,
// queue entry type and sizing constants. No dependencies.
package lse_pkg;

   localparam int HEADER_BYTES    = 54;
   localparam int MAX_MAGIC_BYTES = 8;
   localparam int MAX_EXT_BYTES   = 8;

   localparam int CARRIER_W  = 8;
   localparam int COUNT_W    = 32;
   localparam int BIDX_W     = 5;
   localparam int LEN_W      = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int SECTION_W  = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_BYTES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_LEN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_BYTES   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_LEN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SECRET_SIZE = 3'd4;

   localparam logic [63:0]      MAGIC_BYTES_RST = 64'h2A23;
   localparam logic [LEN_W-1:0] MAGIC_LEN_RST   = 4'd2;
   localparam logic [LEN_W-1:0] EXT_LEN_RST     = 4'd4;

   typedef enum logic [SECTION_W-1:0] {
      SEC_HEADER = 3'd0,
      SEC_MAGIC  = 3'd1,
      SEC_EXTLEN = 3'd2,
      SEC_EXT    = 3'd3,
      SEC_SIZE   = 3'd4,
      SEC_DATA   = 3'd5,
      SEC_TAIL   = 3'd6
   } section_type;

   typedef struct packed {
      logic [CARRIER_W-1:0] carrier;
      logic                 embed;
      logic                 pay_bit;
      logic                 taken;
      section_type          section;
   } entry_type;

endpackage

/* rtl/lse_front.sv */
// Front of the LSB stego embedder: configuration registers, section state
// and per-item classification into a queue entry. Depends on lse_pkg.
module lse_front #(
   parameter int HEADER_BYTES    = lse_pkg::HEADER_BYTES,
   parameter int MAX_MAGIC_BYTES = lse_pkg::MAX_MAGIC_BYTES,
   parameter int MAX_EXT_BYTES   = lse_pkg::MAX_EXT_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lse_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lse_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [lse_pkg::CARRIER_W-1:0]   carrier,
   input  logic [lse_pkg::CARRIER_W-1:0]   secret,
   output logic                            push,
   output lse_pkg::entry_type              entry,
   input  logic                            queue_ready
);

   logic [63:0]                   magic_bytes_ff;
   logic [lse_pkg::LEN_W-1:0]     magic_len_ff;
   logic [63:0]                   ext_bytes_ff;
   logic [lse_pkg::LEN_W-1:0]     ext_len_ff;
   logic [lse_pkg::COUNT_W-1:0]   secret_size_ff;

   lse_pkg::section_type          phase_ff, phase_in, s_phase;
   logic [lse_pkg::COUNT_W-1:0]   count_ff, count_in, s_count;
   logic [lse_pkg::BIDX_W-1:0]    bidx_ff, bidx_in, s_bidx;
   logic [7:0]                    held_ff, held_in;

   logic [lse_pkg::LEN_W-1:0]     eml, eel;
   logic [lse_pkg::COUNT_W-1:0]   eel_field;
   logic [lse_pkg::COUNT_W-1:0]   count_inc;
   logic [2:0]                    bit3;
   logic [2:0]                    bit3_inc;
   logic [7:0]                    data_src;

   assign in_ready = queue_ready;
   assign push     = in_valid & queue_ready;

   assign eml = (magic_len_ff > lse_pkg::LEN_W'(MAX_MAGIC_BYTES)) ?
                lse_pkg::LEN_W'(MAX_MAGIC_BYTES) : magic_len_ff;
   assign eel = (ext_len_ff > lse_pkg::LEN_W'(MAX_EXT_BYTES)) ?
                lse_pkg::LEN_W'(MAX_EXT_BYTES) : ext_len_ff;
   assign eel_field = lse_pkg::COUNT_W'(eel);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_bytes_ff <= lse_pkg::MAGIC_BYTES_RST;
         magic_len_ff   <= lse_pkg::MAGIC_LEN_RST;
         ext_bytes_ff   <= '0;
         ext_len_ff     <= lse_pkg::EXT_LEN_RST;
         secret_size_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            lse_pkg::CSR_MAGIC_BYTES: magic_bytes_ff <= csr_wdata;
            lse_pkg::CSR_MAGIC_LEN:   magic_len_ff   <= csr_wdata[lse_pkg::LEN_W-1:0];
            lse_pkg::CSR_EXT_BYTES:   ext_bytes_ff   <= csr_wdata;
            lse_pkg::CSR_EXT_LEN:     ext_len_ff     <= csr_wdata[lse_pkg::LEN_W-1:0];
            lse_pkg::CSR_SECRET_SIZE: secret_size_ff <= csr_wdata[lse_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // skip sections that are already complete
   always_comb begin
      s_phase = phase_ff;
      s_count = count_ff;
      s_bidx  = bidx_ff;
      unique case (phase_ff) inside
         lse_pkg::SEC_HEADER: begin
            if (count_ff >= lse_pkg::COUNT_W'(HEADER_BYTES)) begin
               s_phase = (eml == '0) ? lse_pkg::SEC_EXTLEN : lse_pkg::SEC_MAGIC;
               s_count = '0;
               s_bidx  = '0;
            end
         end
         lse_pkg::SEC_MAGIC: begin
            if (count_ff >= lse_pkg::COUNT_W'(eml)) begin
               s_phase = lse_pkg::SEC_EXTLEN;
               s_count = '0;
               s_bidx  = '0;
            end
         end
         lse_pkg::SEC_EXT: begin
            if (count_ff >= lse_pkg::COUNT_W'(eel)) begin
               s_phase = lse_pkg::SEC_SIZE;
               s_count = '0;
               s_bidx  = '0;
            end
         end
         lse_pkg::SEC_DATA: begin
            if (count_ff >= secret_size_ff) begin
               s_phase = lse_pkg::SEC_TAIL;
               s_count = '0;
               s_bidx  = '0;
            end
         end
         lse_pkg::SEC_EXTLEN, lse_pkg::SEC_SIZE, lse_pkg::SEC_TAIL: ;
         default: begin
            s_phase = lse_pkg::SEC_TAIL;
            s_count = '0;
            s_bidx  = '0;
         end
      endcase
   end

   assign count_inc = s_count + lse_pkg::COUNT_W'(1);
   assign bit3      = s_bidx[2:0];
   assign bit3_inc  = bit3 + 3'd1;
   assign data_src  = (bit3 == 3'd0) ? secret : held_ff;

   // next state
   always_comb begin
      phase_in = s_phase;
      count_in = s_count;
      bidx_in  = s_bidx;
      held_in  = held_ff;
      unique case (s_phase) inside
         lse_pkg::SEC_HEADER: count_in = count_inc;
         lse_pkg::SEC_MAGIC, lse_pkg::SEC_EXT: begin
            bidx_in = {2'b00, bit3_inc};
            if (bit3_inc == 3'd0) count_in = count_inc;
         end
         lse_pkg::SEC_EXTLEN, lse_pkg::SEC_SIZE: begin
            if (s_bidx == '1) begin
               phase_in = (s_phase == lse_pkg::SEC_EXTLEN) ? lse_pkg::SEC_EXT :
                          lse_pkg::SEC_DATA;
               count_in = '0;
               bidx_in  = '0;
            end else begin
               bidx_in = s_bidx + lse_pkg::BIDX_W'(1);
            end
         end
         lse_pkg::SEC_DATA: begin
            if (bit3 == 3'd0) held_in = secret;
            bidx_in = {2'b00, bit3_inc};
            if (bit3_inc == 3'd0) count_in = count_inc;
         end
         default: ;
      endcase
   end

   // classification outputs
   always_comb begin
      entry.carrier = carrier;
      entry.embed   = 1'b0;
      entry.pay_bit = 1'b0;
      entry.taken   = 1'b0;
      entry.section = s_phase;
      unique case (s_phase)
         lse_pkg::SEC_MAGIC: begin
            entry.embed   = 1'b1;
            entry.pay_bit = magic_bytes_ff[{s_count[2:0], bit3}];
         end
         lse_pkg::SEC_EXTLEN: begin
            entry.embed   = 1'b1;
            entry.pay_bit = eel_field[s_bidx];
         end
         lse_pkg::SEC_EXT: begin
            entry.embed   = 1'b1;
            entry.pay_bit = ext_bytes_ff[{s_count[2:0], bit3}];
         end
         lse_pkg::SEC_SIZE: begin
            entry.embed   = 1'b1;
            entry.pay_bit = secret_size_ff[s_bidx];
         end
         lse_pkg::SEC_DATA: begin
            entry.embed   = 1'b1;
            entry.pay_bit = data_src[bit3];
            entry.taken   = (bit3 == 3'd0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lse_pkg::SEC_HEADER;
         count_ff <= '0;
         bidx_ff  <= '0;
      end else if (push) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         bidx_ff  <= bidx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (push) begin
         held_ff <= held_in;
      end
   end

endmodule

/* rtl/lse_queue.sv */
// Short queue of classified items between front and back of the embedder.
// Depends on lse_pkg.
module lse_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lse_pkg::entry_type wr_entry,
   output logic               in_ready,
   output logic               out_valid,
   input  logic               pop,
   output lse_pkg::entry_type rd_entry
);

   localparam int PTR_W = (lse_pkg::QUEUE_DEPTH > 1) ? $clog2(lse_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(lse_pkg::QUEUE_DEPTH + 1);

   lse_pkg::entry_type  mem [lse_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_pop;

   assign in_ready  = (count_ff != CNT_W'(lse_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign do_pop    = pop & out_valid;
   assign rd_entry  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(lse_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(lse_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/lse_back.sv */
// Back of the embedder: forms the stego byte and holds it in the output
// register until taken. Depends on lse_pkg.
module lse_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_pop,
   input  lse_pkg::entry_type            q_entry,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lse_pkg::CARRIER_W-1:0] stego_byte,
   output logic                          secret_taken,
   output logic [lse_pkg::SECTION_W-1:0] section
);

   logic                          valid_ff, valid_in;
   logic [lse_pkg::CARRIER_W-1:0] stego_ff, stego_in;
   logic                          taken_ff;
   logic [lse_pkg::SECTION_W-1:0] section_ff;
   logic                          load;

   assign load  = q_valid & (~valid_ff | rsp_tready);
   assign q_pop = load;

   assign stego_in = q_entry.embed ?
                     {q_entry.carrier[lse_pkg::CARRIER_W-1:1], q_entry.pay_bit} :
                     q_entry.carrier;
   assign valid_in = load | (valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stego_ff   <= stego_in;
         taken_ff   <= q_entry.taken;
         section_ff <= q_entry.section;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign stego_byte   = stego_ff;
   assign secret_taken = taken_ff;
   assign section      = section_ff;

endmodule

/* rtl/lsb_stego_embedder_top.sv */
// Path: an accepted item is written into the queue and, once the output register is
// free, loaded into it, from which it shows on rsp. Throughput: one item per cycle
// while the queue has room, set by the section/counter update in lse_front; a
// 2-entry queue and the output register let each side stall on its own.
// Reset: section state to header, counters cleared, registers to defaults,
// queue and output empty. Depends on lse_pkg, lse_front, lse_queue, lse_back.
module lsb_stego_embedder_top #(
   parameter int HEADER_BYTES    = lse_pkg::HEADER_BYTES,
   parameter int MAX_MAGIC_BYTES = lse_pkg::MAX_MAGIC_BYTES,
   parameter int MAX_EXT_BYTES   = lse_pkg::MAX_EXT_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lse_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lse_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,  // carrier_byte, secret_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,  // stego_byte
   output logic [3:0]                      rsp_tuser   // secret_taken, section
);

   lse_pkg::entry_type fq_entry, qb_entry;
   logic               push, q_ready, q_valid, q_pop;
   logic               taken;
   logic [lse_pkg::SECTION_W-1:0] section;

   lse_front #(
      .HEADER_BYTES    (HEADER_BYTES),
      .MAX_MAGIC_BYTES (MAX_MAGIC_BYTES),
      .MAX_EXT_BYTES   (MAX_EXT_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .carrier     (req_tdata[7:0]),
      .secret      (req_tdata[15:8]),
      .push        (push),
      .entry       (fq_entry),
      .queue_ready (q_ready)
   );

   lse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_entry  (fq_entry),
      .in_ready  (q_ready),
      .out_valid (q_valid),
      .pop       (q_pop),
      .rd_entry  (qb_entry)
   );

   lse_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_entry      (qb_entry),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .stego_byte   (rsp_tdata),
      .secret_taken (taken),
      .section      (section)
   );

   assign rsp_tuser = {section, taken};

endmodule
